### sv/bptc_pkg.sv
// Package: shared types, register map and arithmetic helpers for the compensation block
package bptc_pkg;

    // Register map: index of each calibration register
    localparam int unsigned NUM_REGS     = 6;
    localparam int unsigned REG_IDX_W    = 3;
    localparam int unsigned PADDR_W      = 5;
    localparam logic [REG_IDX_W-1:0] REG_T1_T2 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_T3_P1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P2_P3 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P4_P5 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P6_P7 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_P8_P9 = 3'd5;

    // Formula constants
    localparam logic [31:0] PRESS_OFFSET = 32'd64000;
    localparam logic [31:0] PRESS_FULL   = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE  = 32'd3125;
    localparam logic [31:0] DIV_BASE     = 32'd32768;
    localparam logic [31:0] TEMP_ROUND   = 32'd128;

    // Sideband that rides alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic        dz;
        logic        big;
    } t_side;

    // Low 32 bits of a product: identical for signed and unsigned operands
    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] m;
        m = a * b;
        return m[31:0];
    endfunction

    // Signed division by 2^k truncating toward zero
    function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input int unsigned k);
        logic [31:0] bias;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return $signed(x + bias) >>> k;
    endfunction

    // Sign-extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

### sv/bptc_ifs.sv
// Interfaces: raw sample channel and compensated result channel
interface bptc_smp_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bptc_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_pa;
    logic signed [31:0] fine_temperature;
    logic               divide_by_zero;
    modport source (output valid, temperature_centi, pressure_pa, fine_temperature,
                    divide_by_zero, input ready);
    modport sink   (input valid, temperature_centi, pressure_pa, fine_temperature,
                    divide_by_zero, output ready);
endinterface

### sv/bptc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage
module bptc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [31:0]          i_num,
    input  logic [31:0]          i_den,
    input  bptc_pkg::t_side      i_side,
    output logic                 o_vld,
    output logic [31:0]          o_quot,
    output bptc_pkg::t_side      o_side
);
    localparam int unsigned STAGES = 32;

    logic             r_vld  [STAGES];
    logic [31:0]      r_rem  [STAGES];
    logic [31:0]      r_num  [STAGES];
    logic [31:0]      r_den  [STAGES];
    bptc_pkg::t_side  r_side [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic            vld_in;
        logic [31:0]     rem_in, num_in, den_in;
        bptc_pkg::t_side side_in;
        logic [32:0]     trial;
        logic            ge;
        logic [31:0]     n_rem;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        // shift in next dividend bit, subtract if it fits
        always_comb begin
            trial = {rem_in, num_in[31]};
            ge    = trial >= {1'b0, den_in};
            n_rem = ge ? 32'(trial - {1'b0, den_in}) : trial[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= {num_in[30:0], ge};
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_quot = r_num[STAGES-1];
    assign o_side = r_side[STAGES-1];

endmodule

### sv/baro_temp_pressure_compensation.sv
// Top level: pipelined temperature and pressure compensation with APB calibration registers
// Takes one raw temperature/pressure pair per cycle and returns one compensated result per
// pair, in order, through nine arithmetic stages, a 32-stage pressure divider (one quotient
// bit per stage) and three correction stages, the last being the output register. The whole
// pipeline holds when the result is not taken; input ready is high whenever the output
// register is empty or being drained. Calibration registers must only be written while no
// sample is in flight. A zero divisor gives pressure 0 and the flag.
module baro_temp_pressure_compensation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bptc_smp_if.sink                           i_smp,
    bptc_res_if.source                         o_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bptc_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    // ---------------- configuration registers ----------------
    logic [31:0]                      r_coef [bptc_pkg::NUM_REGS];
    logic [bptc_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             reg_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bptc_pkg::PADDR_W-1:2];
    assign reg_hit = reg_idx < bptc_pkg::REG_IDX_W'(bptc_pkg::NUM_REGS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bptc_pkg::NUM_REGS; i++) r_coef[i] <= '0;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_coef[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = reg_hit ? r_coef[reg_idx] : '0;
    end

    // coefficient fields, sign- or zero-extended to 32 bits
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'b0, r_coef[bptc_pkg::REG_T1_T2][15:0]};
    assign t2 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_T1_T2][31:16]);
    assign t3 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_T3_P1][15:0]);
    assign p1 = {16'b0, r_coef[bptc_pkg::REG_T3_P1][31:16]};
    assign p2 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P2_P3][15:0]);
    assign p3 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P2_P3][31:16]);
    assign p4 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P4_P5][15:0]);
    assign p5 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P4_P5][31:16]);
    assign p6 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P6_P7][15:0]);
    assign p7 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P6_P7][31:16]);
    assign p8 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P8_P9][15:0]);
    assign p9 = bptc_pkg::sx16(r_coef[bptc_pkg::REG_P8_P9][31:16]);

    // ---------------- pipeline control ----------------
    logic en;
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld, r_h_vld, r_i_vld;
    logic r_k_vld, r_l_vld, r_m_vld;
    logic div_vld;

    // whole pipeline advances unless the output register holds an untaken result
    assign en          = !r_m_vld || o_res.ready;
    assign i_smp.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_b_vld <= 1'b0; r_c_vld <= 1'b0; r_d_vld <= 1'b0;
            r_e_vld <= 1'b0; r_f_vld <= 1'b0; r_g_vld <= 1'b0; r_h_vld <= 1'b0;
            r_i_vld <= 1'b0; r_k_vld <= 1'b0; r_l_vld <= 1'b0; r_m_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_smp.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_k_vld <= div_vld;
            r_l_vld <= r_k_vld;
            r_m_vld <= r_l_vld;
        end
    end

    // ---------------- stage A: first temperature products ----------------
    logic [31:0] a_x1, a_d;
    logic [31:0] r_a_m1, r_a_dd;
    logic [19:0] r_a_up;

    assign a_x1 = {15'b0, i_smp.raw_temperature[19:3]} - {t1[30:0], 1'b0};
    assign a_d  = {16'b0, i_smp.raw_temperature[19:4]} - t1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m1 <= bptc_pkg::mul_lo(a_x1, t2);
            r_a_dd <= bptc_pkg::mul_lo(a_d, a_d);
            r_a_up <= i_smp.raw_pressure;
        end
    end

    // ---------------- stage B ----------------
    logic [31:0] r_b_a, r_b_m3;
    logic [19:0] r_b_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_a  <= bptc_pkg::sdiv_p2(r_a_m1, 11);
            r_b_m3 <= bptc_pkg::mul_lo(bptc_pkg::sdiv_p2(r_a_dd, 12), t3);
            r_b_up <= r_a_up;
        end
    end

    // ---------------- stage C: fine temperature ----------------
    logic [31:0] r_c_fine;
    logic [19:0] r_c_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_fine <= r_b_a + bptc_pkg::sdiv_p2(r_b_m3, 14);
            r_c_up   <= r_b_up;
        end
    end

    // ---------------- stage D ----------------
    logic [31:0] d_pa;
    logic [31:0] r_d_fine, r_d_t5, r_d_pa, r_d_q;
    logic [19:0] r_d_up;

    assign d_pa = bptc_pkg::sdiv_p2(r_c_fine, 1) - bptc_pkg::PRESS_OFFSET;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_fine <= r_c_fine;
            r_d_t5   <= {r_c_fine[29:0], 2'b0} + r_c_fine;
            r_d_pa   <= d_pa;
            r_d_q    <= bptc_pkg::sdiv_p2(d_pa, 2);
            r_d_up   <= r_c_up;
        end
    end

    // ---------------- stage E ----------------
    logic [31:0] r_e_fine, r_e_temp, r_e_qq, r_e_ap5, r_e_ap2;
    logic [19:0] r_e_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_fine <= r_d_fine;
            r_e_temp <= bptc_pkg::sdiv_p2(r_d_t5 + bptc_pkg::TEMP_ROUND, 8);
            r_e_qq   <= bptc_pkg::mul_lo(r_d_q, r_d_q);
            r_e_ap5  <= bptc_pkg::mul_lo(r_d_pa, p5);
            r_e_ap2  <= bptc_pkg::mul_lo(p2, r_d_pa);
            r_e_up   <= r_d_up;
        end
    end

    // ---------------- stage F ----------------
    logic [31:0] r_f_fine, r_f_temp, r_f_b1, r_f_b2, r_f_a1, r_f_ap2;
    logic [19:0] r_f_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_fine <= r_e_fine;
            r_f_temp <= r_e_temp;
            r_f_b1   <= bptc_pkg::mul_lo(bptc_pkg::sdiv_p2(r_e_qq, 11), p6);
            r_f_b2   <= {r_e_ap5[30:0], 1'b0};
            r_f_a1   <= bptc_pkg::mul_lo(p3, bptc_pkg::sdiv_p2(r_e_qq, 13));
            r_f_ap2  <= r_e_ap2;
            r_f_up   <= r_e_up;
        end
    end

    // ---------------- stage G ----------------
    logic [31:0] r_g_fine, r_g_temp, r_g_b, r_g_a2;
    logic [19:0] r_g_up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_fine <= r_f_fine;
            r_g_temp <= r_f_temp;
            r_g_b    <= bptc_pkg::sdiv_p2(r_f_b1 + r_f_b2, 2) + {p4[15:0], 16'b0};
            r_g_a2   <= bptc_pkg::sdiv_p2(bptc_pkg::sdiv_p2(r_f_a1, 3)
                                          + bptc_pkg::sdiv_p2(r_f_ap2, 1), 18);
            r_g_up   <= r_f_up;
        end
    end

    // ---------------- stage H ----------------
    logic [31:0] r_h_fine, r_h_temp, r_h_a3, r_h_pn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_fine <= r_g_fine;
            r_h_temp <= r_g_temp;
            r_h_a3   <= bptc_pkg::mul_lo(bptc_pkg::DIV_BASE + r_g_a2, p1);
            r_h_pn   <= (bptc_pkg::PRESS_FULL - {12'b0, r_g_up})
                        - bptc_pkg::sdiv_p2(r_g_b, 12);
        end
    end

    // ---------------- stage I: divisor and scaled pressure ----------------
    logic [31:0] r_i_fine, r_i_temp, r_i_div, r_i_pm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_fine <= r_h_fine;
            r_i_temp <= r_h_temp;
            r_i_div  <= bptc_pkg::sdiv_p2(r_h_a3, 15);
            r_i_pm   <= bptc_pkg::mul_lo(r_h_pn, bptc_pkg::PRESS_SCALE);
        end
    end

    // ---------------- divider ----------------
    // large values are divided first and doubled after, so the top bit is never lost
    bptc_pkg::t_side div_side_in, div_side;
    logic [31:0]     div_num, div_quot;

    always_comb begin
        div_side_in.temp = r_i_temp;
        div_side_in.fine = r_i_fine;
        div_side_in.dz   = r_i_div == '0;
        div_side_in.big  = r_i_pm[31];
        div_num          = r_i_pm[31] ? r_i_pm : {r_i_pm[30:0], 1'b0};
    end

    bptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_i_vld),
        .i_num   (div_num),
        .i_den   (r_i_div),
        .i_side  (div_side_in),
        .o_vld   (div_vld),
        .o_quot  (div_quot),
        .o_side  (div_side)
    );

    // ---------------- stage K: correction products ----------------
    logic [31:0]     k_p;
    logic [31:0]     r_k_p, r_k_pp, r_k_v2m;
    bptc_pkg::t_side r_k_side;

    assign k_p = div_side.big ? {div_quot[30:0], 1'b0} : div_quot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_p    <= k_p;
            r_k_pp   <= bptc_pkg::mul_lo({3'b0, k_p[31:3]}, {3'b0, k_p[31:3]});
            r_k_v2m  <= bptc_pkg::mul_lo({2'b0, k_p[31:2]}, p8);
            r_k_side <= div_side;
        end
    end

    // ---------------- stage L ----------------
    logic [31:0]     r_l_p, r_l_v1m, r_l_v2;
    bptc_pkg::t_side r_l_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_p    <= r_k_p;
            r_l_v1m  <= bptc_pkg::mul_lo({13'b0, r_k_pp[31:13]}, p9);
            r_l_v2   <= bptc_pkg::sdiv_p2(r_k_v2m, 13);
            r_l_side <= r_k_side;
        end
    end

    // ---------------- stage M: output register ----------------
    logic [31:0] m_sum;
    logic [31:0] r_m_temp, r_m_press, r_m_fine;
    logic        r_m_dz;

    assign m_sum = bptc_pkg::sdiv_p2(r_l_v1m, 12) + r_l_v2 + p7;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_temp  <= r_l_side.temp;
            r_m_fine  <= r_l_side.fine;
            r_m_dz    <= r_l_side.dz;
            r_m_press <= r_l_side.dz ? '0 : r_l_p + bptc_pkg::sdiv_p2(m_sum, 4);
        end
    end

    assign o_res.valid             = r_m_vld;
    assign o_res.temperature_centi = r_m_temp;
    assign o_res.pressure_pa       = r_m_press;
    assign o_res.fine_temperature  = r_m_fine;
    assign o_res.divide_by_zero    = r_m_dz;

    // ---------------- assertions ----------------
    // a zero divisor always yields zero pressure
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.divide_by_zero |-> o_res.pressure_pa == '0)
        else $error("divide_by_zero set with nonzero pressure");

    // temperature and fine temperature stay paired through the divider
    a_temp_fine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.temperature_centi == bptc_pkg::sdiv_p2(
            {o_res.fine_temperature[29:0], 2'b0} + o_res.fine_temperature
            + bptc_pkg::TEMP_ROUND, 8))
        else $error("temperature does not match fine temperature");

    // no result straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    // a stalled divider output cannot advance
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && div_vld |=> div_vld)
        else $error("divider output lost during stall");

endmodule
